FILE: src/ofcc_pkg.sv
// Package for the one-wire frame CRC checker.
// Holds command and status codes, payload types and the CRC-8 byte update.
// No dependencies.
package ofcc_pkg;

   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_NO_PRES  = 2'd1;
   localparam logic [1:0] CMD_BYTE     = 2'd2;
   localparam logic [1:0] CMD_NONE     = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CRC   = 2'd1;
   localparam logic [1:0] STATUS_COMM  = 2'd2;
   localparam logic [1:0] STATUS_ZERO  = 2'd3;

   localparam logic [7:0] CRC_POLY     = 8'h8C;
   localparam logic signed [15:0] CODE_CRC  = 16'sd16000;
   localparam logic signed [15:0] CODE_COMM = 16'sd17600;
   localparam logic signed [15:0] CODE_ZERO = 16'sd19200;

   localparam logic       KIND_SCRATCH = 1'b0;
   localparam logic [3:0] LAST_SCRATCH = 4'd8;
   localparam logic [3:0] LAST_ROM     = 4'd7;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic signed [15:0] temperature;
      logic [63:0]       rom_code;
      logic signed [15:0] coded_value;
   } result_type;

   // reflected CRC-8, one byte, LSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] crc;
      logic [7:0] data;
      logic       mix;
      crc  = crc_i;
      data = data_i;
      for (int k = 0; k < 8; k++) begin
         mix  = crc[0] ^ data[0];
         crc  = crc >> 1;
         if (mix) begin
            crc = crc ^ CRC_POLY;
         end
         data = data >> 1;
      end
      return crc;
   endfunction

endpackage

FILE: src/ofcc_req_if.sv
// Request channel interface: valid/ready handshake with cmd and rx_byte.
// Depends on nothing.
interface ofcc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;

   modport source (output valid, cmd, rx_byte, input ready);
   modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

FILE: src/ofcc_rsp_if.sv
// Result channel interface: valid/ready handshake with the frame check result.
// Depends on nothing.
interface ofcc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [15:0] temperature;
   logic [63:0]        rom_code;
   logic signed [15:0] coded_value;

   modport source (output valid, status, temperature, rom_code, coded_value, input ready);
   modport sink   (input valid, status, temperature, rom_code, coded_value, output ready);
endinterface

FILE: src/onewire_frame_crc_checker.sv
// One-wire frame CRC checker, top level.
// Path from request accept to result valid: input register, then result register.
// Throughput: one request per cycle while the result channel does not stall; the CRC-8 byte update is combinational.
// Reset (synchronous, active high): no frame open, CRC and count zero, frame_kind scratchpad.
// Depends on ofcc_pkg, ofcc_req_if, ofcc_rsp_if, ofcc_in_stage, ofcc_frame_engine.
module onewire_frame_crc_checker (
   input  logic   clock,
   input  logic   reset,
   ofcc_req_if.sink   req_chan,
   ofcc_rsp_if.source rsp_chan,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   logic                 kind_ff;
   logic                 advance;
   logic                 stage_valid;
   logic                 fire;
   ofcc_pkg::req_type    req_item;
   ofcc_pkg::req_type    stage_item;
   ofcc_pkg::result_type result;
   ofcc_pkg::result_type rsp_ff, rsp_in;

   assign req_item.cmd     = req_chan.cmd;
   assign req_item.rx_byte = req_chan.rx_byte;

   assign advance = !rsp_ff.valid || rsp_chan.ready;
   assign fire    = stage_valid && advance;

   ofcc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   ofcc_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (stage_item),
      .frame_kind (kind_ff),
      .result     (result)
   );

   assign rsp_in = advance ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            kind_ff <= csr_wr_data;
         end
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status      <= rsp_in.status;
      rsp_ff.temperature <= rsp_in.temperature;
      rsp_ff.rom_code    <= rsp_in.rom_code;
      rsp_ff.coded_value <= rsp_in.coded_value;
   end

   assign rsp_chan.valid       = rsp_ff.valid;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.temperature = rsp_ff.temperature;
   assign rsp_chan.rom_code    = rsp_ff.rom_code;
   assign rsp_chan.coded_value = rsp_ff.coded_value;

   a_comm_result: assert property (@(posedge clock) disable iff (reset)
      fire && stage_item.cmd == ofcc_pkg::CMD_NO_PRES
      |=> rsp_chan.valid && rsp_chan.status == ofcc_pkg::STATUS_COMM)
      else $error("missing communication error result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      stage_valid && rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while pipeline stalled");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      fire && (stage_item.cmd == ofcc_pkg::CMD_START || stage_item.cmd == ofcc_pkg::CMD_NONE)
      |=> !rsp_chan.valid)
      else $error("result produced by a start or unused command");

endmodule

FILE: src/ofcc_in_stage.sv
// Input register of the frame checker: holds one request until the engine takes it.
// Depends on ofcc_pkg.
module ofcc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ofcc_pkg::req_type req_item,
   input  logic              advance,
   output logic              stage_valid,
   output ofcc_pkg::req_type stage_item
);

   logic              valid_ff, valid_in;
   ofcc_pkg::req_type item_ff;

   assign req_ready   = !valid_ff || advance;
   assign valid_in    = req_ready ? req_valid : valid_ff;
   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: src/ofcc_frame_engine.sv
// Frame state and check logic: byte count, running CRC, zero detect, byte store.
// Depends on ofcc_pkg (codes, types, crc8_byte).
module ofcc_frame_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ofcc_pkg::req_type    item,
   input  logic                 frame_kind,
   output ofcc_pkg::result_type result
);

   logic        open_ff, open_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic        zero_ff, zero_in;
   logic [63:0] bytes_ff, bytes_in;

   logic [3:0]  last;
   logic [63:0] rom_bytes;
   logic        zero_fin;
   logic [7:0]  b;

   assign b    = item.rx_byte;
   assign last = (frame_kind == ofcc_pkg::KIND_SCRATCH) ? ofcc_pkg::LAST_SCRATCH
                                                        : ofcc_pkg::LAST_ROM;
   assign rom_bytes = {b, bytes_ff[55:0]};
   assign zero_fin  = zero_ff && ((frame_kind == ofcc_pkg::KIND_SCRATCH) || (b == 8'd0));

   always_comb begin
      open_in  = open_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      zero_in  = zero_ff;
      bytes_in = bytes_ff;
      result   = '0;
      if (fire) begin
         unique case (item.cmd)
            ofcc_pkg::CMD_START: begin
               open_in  = 1'b1;
               count_in = '0;
               crc_in   = '0;
               zero_in  = 1'b1;
               bytes_in = '0;
            end
            ofcc_pkg::CMD_NO_PRES: begin
               open_in            = 1'b0;
               count_in           = '0;
               crc_in             = '0;
               zero_in            = 1'b1;
               bytes_in           = '0;
               result.valid       = 1'b1;
               result.status      = ofcc_pkg::STATUS_COMM;
               result.coded_value = ofcc_pkg::CODE_COMM;
            end
            ofcc_pkg::CMD_BYTE: begin
               if (open_ff) begin
                  if (count_ff < last) begin
                     bytes_in = bytes_ff | ({56'd0, b} << {count_ff[2:0], 3'b000});
                     zero_in  = zero_ff && (b == 8'd0);
                     crc_in   = ofcc_pkg::crc8_byte(crc_ff, b);
                     count_in = count_ff + 4'd1;
                  end else begin
                     // last byte carries the received CRC
                     result.valid = 1'b1;
                     if (frame_kind != ofcc_pkg::KIND_SCRATCH) begin
                        result.rom_code = rom_bytes;
                     end
                     priority if (zero_fin) begin
                        result.status      = ofcc_pkg::STATUS_ZERO;
                        result.coded_value = ofcc_pkg::CODE_ZERO;
                     end else if (crc_ff != b) begin
                        result.status      = ofcc_pkg::STATUS_CRC;
                        result.coded_value = ofcc_pkg::CODE_CRC;
                     end else begin
                        result.status = ofcc_pkg::STATUS_OK;
                        if (frame_kind == ofcc_pkg::KIND_SCRATCH) begin
                           result.temperature = bytes_ff[15:0];
                           result.coded_value = bytes_ff[15:0];
                        end
                     end
                     open_in  = 1'b0;
                     count_in = '0;
                     crc_in   = '0;
                     zero_in  = 1'b1;
                     bytes_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         count_ff <= '0;
         crc_ff   <= '0;
         zero_ff  <= 1'b1;
         bytes_ff <= '0;
      end else begin
         open_ff  <= open_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         zero_ff  <= zero_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule
